>>> sv/upd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and helper functions of the URI percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int UPD_QDEPTH = 4;
  localparam int UPD_QPTR_W = $clog2(UPD_QDEPTH);
  localparam int UPD_QCNT_W = $clog2(UPD_QDEPTH + 1);

  localparam logic [15:0] PERCENT = 16'h0025;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    J_UNIT  = 2'd0,
    J_KEEP  = 2'd1,
    J_CODE  = 2'd2,
    J_ERROR = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [20:0] data;
    logic        last;
  } job_t;

  function automatic logic is_hex(input logic [15:0] u);
    is_hex = (u >= 16'h0030 && u <= 16'h0039) ||
             (u >= 16'h0041 && u <= 16'h0046) ||
             (u >= 16'h0061 && u <= 16'h0066);
  endfunction

  function automatic logic [3:0] hex_val(input logic [6:0] c);
    hex_val = c[4] ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  function automatic logic is_reserved(input logic [6:0] c);
    is_reserved = c == 7'h3B || c == 7'h2F || c == 7'h3F || c == 7'h3A ||
                  c == 7'h40 || c == 7'h26 || c == 7'h3D || c == 7'h2B ||
                  c == 7'h24 || c == 7'h2C || c == 7'h23;
  endfunction

endpackage
`default_nettype wire

>>> sv/upd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_front
// Escape parser: takes one code unit per cycle while accept is high, tracks escapes and UTF-8
// sequences, and pushes one job per unit that yields results.
// ----------------------------------------------------------------------------
module upd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          accept,
  input  wire logic [15:0]   unit,
  input  wire logic          last,
  output upd_pkg::job_t      job,
  output logic               push
);

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_ESC_HI   = 3'd1,
    PH_ESC_LO   = 3'd2,
    PH_CONT_PCT = 3'd3,
    PH_CONT_HI  = 3'd4,
    PH_CONT_LO  = 3'd5,
    PH_ERROR    = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        keep_r;
  logic [6:0]  held_r, held_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  oct0_r, oct0_nxt;
  logic [7:0]  oct1_r, oct1_nxt;
  logic [7:0]  oct2_r, oct2_nxt;

  logic [7:0]  b;
  logic        hex_ok;
  logic [7:0]  m1, m2;
  logic [20:0] v;
  logic        seq_bad;
  logic [2:0]  idx_inc;

  assign hex_ok  = upd_pkg::is_hex(unit);
  assign b       = {upd_pkg::hex_val(held_r), upd_pkg::hex_val(unit[6:0])};
  assign m1      = (idx_r == 3'd1) ? b : oct1_r;
  assign m2      = (idx_r == 3'd2) ? b : oct2_r;
  assign idx_inc = idx_r + 3'd1;

  always_comb begin
    v       = '0;
    seq_bad = 1'b0;
    if (len_r == 3'd2) begin
      v       = {10'd0, oct0_r[4:0], m1[5:0]};
      seq_bad = (oct0_r == 8'hC0) || (oct0_r == 8'hC1);
    end else if (len_r == 3'd3) begin
      v       = {5'd0, oct0_r[3:0], m1[5:0], m2[5:0]};
      seq_bad = (oct0_r[3:0] == 4'hD && m1[5]) || (oct0_r == 8'hE0 && !m1[5]);
    end else begin
      v       = {oct0_r[2:0], m1[5:0], m2[5:0], b[5:0]};
      seq_bad = (oct0_r == 8'hF0) && (m1[5:4] == 2'b00);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    oct0_nxt  = oct0_r;
    oct1_nxt  = oct1_r;
    oct2_nxt  = oct2_r;
    push      = 1'b0;
    job       = '0;
    if (accept) begin
      unique case (phase_r)
        PH_NORMAL: begin
          if (unit != upd_pkg::PERCENT) begin
            push     = 1'b1;
            job.kind = upd_pkg::J_UNIT;
            job.data = {5'd0, unit};
          end else begin
            phase_nxt = PH_ESC_HI;
          end
        end
        PH_ESC_HI, PH_CONT_HI: begin
          if (hex_ok) begin
            held_nxt  = unit[6:0];
            phase_nxt = (phase_r == PH_ESC_HI) ? PH_ESC_LO : PH_CONT_LO;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_ESC_LO: begin
          if (!hex_ok) begin
            phase_nxt = PH_ERROR;
          end else if (!b[7]) begin
            push      = 1'b1;
            phase_nxt = PH_NORMAL;
            if (keep_r && upd_pkg::is_reserved(b[6:0])) begin
              job.kind = upd_pkg::J_KEEP;
              job.data = {7'd0, held_r, unit[6:0]};
            end else begin
              job.kind = upd_pkg::J_UNIT;
              job.data = {13'd0, b};
            end
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            len_nxt   = (b[7:5] == 3'b110) ? 3'd2 : ((b[7:4] == 4'b1110) ? 3'd3 : 3'd4);
            oct0_nxt  = b;
            idx_nxt   = 3'd1;
            phase_nxt = PH_CONT_PCT;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_CONT_PCT: begin
          phase_nxt = (unit == upd_pkg::PERCENT) ? PH_CONT_HI : PH_ERROR;
        end
        PH_CONT_LO: begin
          if (!hex_ok || b[7:6] != 2'b10) begin
            phase_nxt = PH_ERROR;
          end else begin
            if (idx_r == 3'd1) oct1_nxt = b;
            if (idx_r == 3'd2) oct2_nxt = b;
            idx_nxt = idx_inc;
            if (idx_inc < len_r) begin
              phase_nxt = PH_CONT_PCT;
            end else if (seq_bad) begin
              phase_nxt = PH_ERROR;
            end else begin
              push      = 1'b1;
              job.kind  = upd_pkg::J_CODE;
              job.data  = v;
              phase_nxt = PH_NORMAL;
            end
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
      if (last) begin
        idx_nxt = 3'd0;
        if (phase_nxt != PH_NORMAL) begin
          push      = 1'b1;
          job.kind  = upd_pkg::J_ERROR;
          job.data  = '0;
          phase_nxt = PH_NORMAL;
        end
      end
      job.last = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      keep_r  <= 1'b1;
      held_r  <= '0;
      len_r   <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) keep_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    oct0_r <= oct0_nxt;
    oct1_r <= oct1_nxt;
    oct2_r <= oct2_nxt;
  end

endmodule
`default_nettype wire

>>> sv/upd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_fifo
// Short job queue between the escape parser and the output serializer.
// ----------------------------------------------------------------------------
module upd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire upd_pkg::job_t push_job,
  input  wire logic          pop,
  output upd_pkg::job_t      head,
  output logic               not_empty,
  output logic               full
);

  upd_pkg::job_t                  mem_r [upd_pkg::UPD_QDEPTH];
  logic [upd_pkg::UPD_QPTR_W-1:0] wr_r, wr_nxt;
  logic [upd_pkg::UPD_QPTR_W-1:0] rd_r, rd_nxt;
  logic [upd_pkg::UPD_QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full      = (cnt_r == upd_pkg::UPD_QCNT_W'(upd_pkg::UPD_QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule
`default_nettype wire

>>> sv/upd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upd_back
// Output serializer: expands each job into one to three code units and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module upd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire upd_pkg::job_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  logic [1:0]  sub_r, sub_nxt;
  logic        vld_r, vld_nxt;
  logic [15:0] unit_r;
  logic        eos_r, err_r;
  logic [1:0]  n_m1;
  logic [15:0] sel;
  logic        load, last_piece, pair;
  logic [20:0] w;

  assign w    = head.data - upd_pkg::SUPP_BASE;
  assign pair = (head.data[20:16] != 5'd0);

  always_comb begin
    n_m1 = 2'd0;
    sel  = '0;
    case (head.kind)
      upd_pkg::J_UNIT: begin
        sel = head.data[15:0];
      end
      upd_pkg::J_KEEP: begin
        n_m1 = 2'd2;
        if (sub_r == 2'd0)      sel = upd_pkg::PERCENT;
        else if (sub_r == 2'd1) sel = {9'd0, head.data[13:7]};
        else                    sel = {9'd0, head.data[6:0]};
      end
      upd_pkg::J_CODE: begin
        n_m1 = pair ? 2'd1 : 2'd0;
        if (!pair)              sel = head.data[15:0];
        else if (sub_r == 2'd0) sel = upd_pkg::HI_SURR_BASE | {6'd0, w[19:10]};
        else                    sel = upd_pkg::LO_SURR_BASE | {6'd0, w[9:0]};
      end
      default: begin
        sel = '0;
      end
    endcase
  end

  assign load       = head_valid && (!vld_r || out_tready);
  assign last_piece = (sub_r == n_m1);
  assign pop        = load && last_piece;

  always_comb begin
    sub_nxt = sub_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      sub_nxt = last_piece ? 2'd0 : sub_r + 2'd1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
      vld_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= sel;
      eos_r  <= head.last && last_piece;
      err_r  <= (head.kind == upd_pkg::J_ERROR);
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = unit_r;
  assign out_tlast  = eos_r;
  assign out_tuser  = err_r;

endmodule
`default_nettype wire

>>> sv/uri_percent_decoder_utf8_to_utf16.sv
`default_nettype none
// Path: an item's first result goes through the job queue write, then the
// output register.
// Throughput: one item per cycle while the job queue is not full; the output side
// sends one result per cycle while out_tready is high, so a kept reserved escape
// (3 results) or a surrogate pair (2 results) holds the output for each of its
// results, buffered by a 4-job queue. Reset: synchronous active-low rst_n; keep_reserved resets to 1.
// ----------------------------------------------------------------------------
// uri_percent_decoder_utf8_to_utf16
// Streams UTF-16 URI code units in and decoded UTF-16 code units out.
// ----------------------------------------------------------------------------
module uri_percent_decoder_utf8_to_utf16 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,    // keep_reserved
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // code_unit
  input  wire logic        in_tlast,     // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // out_unit
  output logic             out_tlast,    // end_of_string
  output logic             out_tuser     // decode_error
);

  upd_pkg::job_t push_job, head;
  logic          push, pop, head_valid, full, accept;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  upd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .unit      (in_tdata),
    .last      (in_tlast),
    .job       (push_job),
    .push      (push)
  );

  upd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (full)
  );

  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
